// ===== rtl/fdnd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdnd_pkg
// Shared types, constants and name helpers for the directory entry decoder.
// ----------------------------------------------------------------------------
package fdnd_pkg;

    localparam int NAME_CHARS_DEFAULT = 256;

    localparam logic [7:0] BYTE_DELETED = 8'hE5;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [15:0] CHAR_DOT    = 16'h002E;
    localparam logic [3:0] LFN_MASK     = 4'hF;
    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = 3;
    localparam int LFN_CHARS = 13;

    // byte offsets of the 13 UTF-16 characters of a long-name slot
    localparam logic [4:0] LFN_OFFS [LFN_CHARS] =
        '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22,
          5'd24, 5'd28, 5'd30};

    typedef logic [15:0][15:0] char_vec_t;

    typedef struct packed {
        char_vec_t  chars;
        logic [3:0] n;
    } short_name_t;

    // controller -> datapath
    typedef struct packed {
        logic load_entry;
        logic prep_start;
        logic prep_new_group;
        logic short_start;
        logic wr_step;
        logic clear_group;
        logic set_ended;
        logic emit_long_start;
        logic emit_short_start;
        logic rd_issue;
        logic rd_capture;
        logic push_chunk;
        logic push_eod;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ended;
        logic in_group;
        logic is_long;
        logic first_zero;
        logic first_deleted;
        logic wr_done;
        logic wr_short;
        logic chunk_full;
        logic remain_zero;
        logic out_free;
    } status_t;

    function automatic logic [15:0] lower_ascii(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
            r = b + 8'h20;
        return {8'h00, r};
    endfunction

    function automatic char_vec_t lfn_chars(input logic [255:0] e);
        char_vec_t r;
        r = '0;
        for (int k = 0; k < LFN_CHARS; k++)
            r[k] = e[{LFN_OFFS[k], 3'b000} +: 16];
        return r;
    endfunction

    // characters up to the first zero
    function automatic logic [3:0] lfn_len(input char_vec_t c);
        logic [3:0] n;
        logic       stop;
        n = '0;
        stop = 1'b0;
        for (int k = 0; k < LFN_CHARS; k++) begin
            if (stop || c[k] == 16'h0000)
                stop = 1'b1;
            else
                n = n + 4'd1;
        end
        return n;
    endfunction

    // 8.3 form: base cut at space/zero, lowercase, dot before non-blank extension
    function automatic short_name_t short_name(input logic [255:0] e);
        short_name_t r;
        logic [3:0]  blen;
        logic [3:0]  elen;
        logic        bstop;
        logic        estop;
        logic        dot;
        logic [7:0]  b;
        blen  = '0;
        elen  = '0;
        bstop = 1'b0;
        estop = 1'b0;
        for (int k = 0; k < BASE_LEN; k++) begin
            b = e[8*k +: 8];
            if (bstop || b == BYTE_SPACE || b == 8'h00)
                bstop = 1'b1;
            else
                blen = blen + 4'd1;
        end
        for (int k = 0; k < EXT_LEN; k++) begin
            b = e[8*(BASE_LEN+k) +: 8];
            if (estop || b == BYTE_SPACE || b == 8'h00)
                estop = 1'b1;
            else
                elen = elen + 4'd1;
        end
        dot = (e[8*BASE_LEN +: 8] != BYTE_SPACE);
        r.chars = '0;
        for (int k = 0; k < BASE_LEN; k++) begin
            if (4'(k) < blen)
                r.chars[k] = lower_ascii(e[8*k +: 8]);
        end
        if (dot) begin
            r.chars[blen] = CHAR_DOT;
            for (int k = 0; k < EXT_LEN; k++) begin
                if (4'(k) < elen)
                    r.chars[4'(blen + 4'd1 + 4'(k))] = lower_ascii(e[8*(BASE_LEN+k) +: 8]);
            end
        end
        r.n = dot ? (blen + 4'd1 + elen) : blen;
        return r;
    endfunction

endpackage

// ===== rtl/fat_directory_entry_name_decoder.sv =====
// ----------------------------------------------------------------------------
// fat_directory_entry_name_decoder
// Rebuilds item names from FAT directory entries (long-name groups or 8.3
// short names) and emits them up to four characters per result.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  entry_bytes_0_7 .. entry_bytes_24_31
//  out      out_valid/ out_stall result_kind, char_a..char_d, char_count,
//                                last_of_run, attributes, file_size,
//                                first_cluster, name_truncated
//
//  One entry at a time: the entry is accepted and then classified; a long-name
//  slot writes its kept characters into the name buffer, a short name its
//  decoded characters. Emission reads the name buffer one character at a time
//  (read issue, then capture) and pushes a result per four characters or fewer.
//  A result waits in the output register under out_stall while the next entry
//  is taken. Reset is asynchronous; the name buffer needs no clearing pass.
// ----------------------------------------------------------------------------
module fat_directory_entry_name_decoder #(
    parameter int NAME_CHARS = fdnd_pkg::NAME_CHARS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] entry_bytes_0_7,
    input  logic [63:0] entry_bytes_8_15,
    input  logic [63:0] entry_bytes_16_23,
    input  logic [63:0] entry_bytes_24_31,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [15:0] char_a,
    output logic [15:0] char_b,
    output logic [15:0] char_c,
    output logic [15:0] char_d,
    output logic [2:0]  char_count,
    output logic        last_of_run,
    output logic [7:0]  attributes,
    output logic [31:0] file_size,
    output logic [15:0] first_cluster,
    output logic        name_truncated
);

    import fdnd_pkg::*;

    cmd_t    cmd;
    status_t status;

    fdnd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fdnd_datapath #(
        .NAME_CHARS (NAME_CHARS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .entry_bytes_0_7   (entry_bytes_0_7),
        .entry_bytes_8_15  (entry_bytes_8_15),
        .entry_bytes_16_23 (entry_bytes_16_23),
        .entry_bytes_24_31 (entry_bytes_24_31),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .result_kind       (result_kind),
        .char_a            (char_a),
        .char_b            (char_b),
        .char_c            (char_c),
        .char_d            (char_d),
        .char_count        (char_count),
        .last_of_run       (last_of_run),
        .attributes        (attributes),
        .file_size         (file_size),
        .first_cluster     (first_cluster),
        .name_truncated    (name_truncated)
    );

endmodule

// ===== rtl/fdnd_ram.sv =====
// ----------------------------------------------------------------------------
// fdnd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdnd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/fdnd_datapath.sv =====
// ----------------------------------------------------------------------------
// fdnd_datapath
// Entry register, name buffer bookkeeping, character writer, chunk assembly
// and the result output register.
// ----------------------------------------------------------------------------
module fdnd_datapath #(
    parameter int NAME_CHARS = fdnd_pkg::NAME_CHARS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fdnd_pkg::cmd_t    cmd,
    output fdnd_pkg::status_t status,
    input  logic [63:0]       entry_bytes_0_7,
    input  logic [63:0]       entry_bytes_8_15,
    input  logic [63:0]       entry_bytes_16_23,
    input  logic [63:0]       entry_bytes_24_31,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              result_kind,
    output logic [15:0]       char_a,
    output logic [15:0]       char_b,
    output logic [15:0]       char_c,
    output logic [15:0]       char_d,
    output logic [2:0]        char_count,
    output logic              last_of_run,
    output logic [7:0]        attributes,
    output logic [31:0]       file_size,
    output logic [15:0]       first_cluster,
    output logic              name_truncated
);

    import fdnd_pkg::*;

    localparam int PTR_W  = $clog2(NAME_CHARS + 1);
    localparam int ADDR_W = $clog2(NAME_CHARS);
    localparam logic [PTR_W-1:0] START_EMPTY = PTR_W'(NAME_CHARS);

    logic [255:0]     entry_reg;
    logic [PTR_W-1:0] name_start_reg;
    logic             group_reg;
    logic             ovf_reg;
    logic             ended_reg;

    logic [PTR_W-1:0] wr_base_reg;
    logic [3:0]       wr_off_reg;
    logic [3:0]       wr_cnt_reg;
    logic [3:0]       wr_idx_reg;
    logic             wr_short_reg;

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] remain_reg;
    logic [3:0][15:0] chunk_reg;
    logic [2:0]       chunk_cnt_reg;
    logic             trunc_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [3:0][15:0] out_chars_reg;
    logic [2:0]       out_count_reg;
    logic             out_last_reg;
    logic [7:0]       out_attr_reg;
    logic [31:0]      out_size_reg;
    logic [15:0]      out_clus_reg;
    logic             out_trunc_reg;

    char_vec_t        lfn;
    logic [3:0]       len;
    logic [PTR_W-1:0] eff_start;
    logic             ovf;
    logic [3:0]       keep;
    logic [3:0]       drop;
    logic [PTR_W-1:0] new_start;
    short_name_t      sname;

    logic [PTR_W-1:0] wr_addr_full;
    logic [15:0]      wr_data;
    logic [15:0]      rd_data;
    logic             out_free;

    // slot decode and placement in front of the buffered name
    always_comb
    begin
        lfn       = lfn_chars(entry_reg);
        len       = lfn_len(lfn);
        eff_start = cmd.prep_new_group ? START_EMPTY : name_start_reg;
        ovf       = PTR_W'(len) > eff_start;
        keep      = ovf ? eff_start[3:0] : len;
        drop      = ovf ? (len - eff_start[3:0]) : 4'd0;
        new_start = eff_start - PTR_W'(keep);
        sname     = short_name(entry_reg);
    end

    assign wr_addr_full = wr_base_reg + PTR_W'(wr_idx_reg);
    assign wr_data      = wr_short_reg ? sname.chars[wr_idx_reg]
                                       : lfn[4'(wr_off_reg + wr_idx_reg)];
    assign out_free     = !out_valid_reg || !out_stall;

    fdnd_ram #(
        .WIDTH (16),
        .DEPTH (NAME_CHARS)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_step),
        .wr_addr (wr_addr_full[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_issue),
        .rd_addr (ptr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_start_reg <= START_EMPTY;
            group_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            ended_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            wr_base_reg    <= '0;
            wr_off_reg     <= '0;
            wr_cnt_reg     <= '0;
            wr_idx_reg     <= '0;
            wr_short_reg   <= 1'b0;
            ptr_reg        <= '0;
            chunk_reg      <= '0;
            chunk_cnt_reg  <= '0;
            remain_reg     <= '0;
            trunc_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.set_ended)
                ended_reg <= 1'b1;
            if (cmd.clear_group)
                group_reg <= 1'b0;

            if (cmd.prep_start)
            begin
                name_start_reg <= new_start;
                group_reg      <= 1'b1;
                ovf_reg        <= cmd.prep_new_group ? ovf : (ovf_reg | ovf);
                wr_base_reg    <= new_start;
                wr_off_reg     <= drop;
                wr_cnt_reg     <= keep;
                wr_idx_reg     <= '0;
                wr_short_reg   <= 1'b0;
            end
            else if (cmd.short_start)
            begin
                wr_base_reg  <= '0;
                wr_off_reg   <= '0;
                wr_cnt_reg   <= sname.n;
                wr_idx_reg   <= '0;
                wr_short_reg <= 1'b1;
            end
            else if (cmd.wr_step)
                wr_idx_reg <= wr_idx_reg + 4'd1;

            if (cmd.emit_long_start)
            begin
                ptr_reg       <= name_start_reg;
                remain_reg    <= START_EMPTY - name_start_reg;
                trunc_reg     <= ovf_reg;
                chunk_reg     <= '0;
                chunk_cnt_reg <= '0;
            end
            else if (cmd.emit_short_start)
            begin
                ptr_reg       <= '0;
                remain_reg    <= PTR_W'(wr_cnt_reg);
                trunc_reg     <= 1'b0;
                chunk_reg     <= '0;
                chunk_cnt_reg <= '0;
            end
            else if (cmd.rd_capture)
            begin
                chunk_reg[chunk_cnt_reg[1:0]] <= rd_data;
                chunk_cnt_reg <= chunk_cnt_reg + 3'd1;
                ptr_reg       <= ptr_reg + PTR_W'(1);
                remain_reg    <= remain_reg - PTR_W'(1);
            end
            else if (cmd.push_chunk)
            begin
                chunk_reg     <= '0;
                chunk_cnt_reg <= '0;
            end

            if (cmd.push_chunk || cmd.push_eod)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
            entry_reg <= {entry_bytes_24_31, entry_bytes_16_23,
                          entry_bytes_8_15, entry_bytes_0_7};
        if (cmd.push_chunk)
        begin
            out_kind_reg  <= 1'b0;
            out_chars_reg <= chunk_reg;
            out_count_reg <= chunk_cnt_reg;
            out_last_reg  <= (remain_reg == '0);
            out_attr_reg  <= entry_reg[95:88];
            out_size_reg  <= entry_reg[255:224];
            out_clus_reg  <= entry_reg[223:208];
            out_trunc_reg <= trunc_reg;
        end
        else if (cmd.push_eod)
        begin
            out_kind_reg  <= 1'b1;
            out_chars_reg <= '0;
            out_count_reg <= '0;
            out_last_reg  <= 1'b1;
            out_attr_reg  <= '0;
            out_size_reg  <= '0;
            out_clus_reg  <= '0;
            out_trunc_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.ended         = ended_reg;
        status.in_group      = group_reg;
        status.is_long       = (entry_reg[91:88] == LFN_MASK);
        status.first_zero    = (entry_reg[7:0] == 8'h00);
        status.first_deleted = (entry_reg[7:0] == BYTE_DELETED);
        status.wr_done       = (wr_idx_reg == wr_cnt_reg);
        status.wr_short      = wr_short_reg;
        status.chunk_full    = chunk_cnt_reg[2];
        status.remain_zero   = (remain_reg == '0);
        status.out_free      = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign char_a         = out_chars_reg[0];
    assign char_b         = out_chars_reg[1];
    assign char_c         = out_chars_reg[2];
    assign char_d         = out_chars_reg[3];
    assign char_count     = out_count_reg;
    assign last_of_run    = out_last_reg;
    assign attributes     = out_attr_reg;
    assign file_size      = out_size_reg;
    assign first_cluster  = out_clus_reg;
    assign name_truncated = out_trunc_reg;

endmodule

// ===== rtl/fdnd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fdnd_ctrl
// Sequencer: classifies an entry, runs the character writer and the chunk
// emitter, and holds off the input channel while busy.
// ----------------------------------------------------------------------------
module fdnd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fdnd_pkg::status_t status,
    output fdnd_pkg::cmd_t    cmd
);

    import fdnd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_FILL,
        S_CAP,
        S_PUSH,
        S_EOD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.load_entry = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.ended)
                    state_next = S_IDLE;
                else if (status.in_group)
                begin
                    if (status.is_long)
                    begin
                        if (status.first_deleted)
                            state_next = S_IDLE;
                        else
                        begin
                            cmd.prep_start = 1'b1;
                            state_next     = S_WRITE;
                        end
                    end
                    else
                    begin
                        cmd.clear_group     = 1'b1;
                        cmd.emit_long_start = 1'b1;
                        state_next          = S_FILL;
                    end
                end
                else if (status.first_zero)
                begin
                    cmd.set_ended = 1'b1;
                    state_next    = S_EOD;
                end
                else if (status.first_deleted)
                    state_next = S_IDLE;
                else if (status.is_long)
                begin
                    cmd.prep_start     = 1'b1;
                    cmd.prep_new_group = 1'b1;
                    state_next         = S_WRITE;
                end
                else
                begin
                    cmd.short_start = 1'b1;
                    state_next      = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!status.wr_done)
                    cmd.wr_step = 1'b1;
                else if (status.wr_short)
                begin
                    cmd.emit_short_start = 1'b1;
                    state_next           = S_FILL;
                end
                else
                    state_next = S_IDLE;
            end
            S_FILL:
            begin
                if (!status.chunk_full && !status.remain_zero)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_CAP;
                end
                else
                    state_next = S_PUSH;
            end
            S_CAP:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_FILL;
            end
            S_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push_chunk = 1'b1;
                    state_next     = status.remain_zero ? S_IDLE : S_FILL;
                end
            end
            S_EOD:
            begin
                if (status.out_free)
                begin
                    cmd.push_eod = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule
